@@ rtl/polyline_box_clipper_3d_core_assert.svh @@
// Assertion macros for the polyline box clipper
`ifndef POLYLINE_BOX_CLIPPER_3D_CORE_ASSERT_SVH
`define POLYLINE_BOX_CLIPPER_3D_CORE_ASSERT_SVH
// implication checked on every edge out of reset
`define PBC_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// next-cycle implication
`define PBC_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

@@ rtl/pbc3d_pkg.sv @@
// ----------------------------------------------------------------------------
// pbc3d_pkg
// Shared types and codes for the polyline box clipper.
// ----------------------------------------------------------------------------
package pbc3d_pkg;

    localparam int unsigned NUM_REGS = 6;
    localparam int unsigned IDX_W = 3;

    localparam logic [IDX_W-1:0] REG_X_LO = 3'd0;
    localparam logic [IDX_W-1:0] REG_X_HI = 3'd1;
    localparam logic [IDX_W-1:0] REG_Y_LO = 3'd2;
    localparam logic [IDX_W-1:0] REG_Y_HI = 3'd3;
    localparam logic [IDX_W-1:0] REG_Z_LO = 3'd4;
    localparam logic [IDX_W-1:0] REG_Z_HI = 3'd5;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input, compute inside test
        logic face_start; // set up face (face index)
        logic [2:0] face;
        logic axis_start; // start divide for the given other axis
        logic axis_sel;   // 0: first other axis, 1: second
        logic face_commit;
        logic emit_inside;
        logic emit_cross;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_box;
        logic last_inside;
        logic face_try;
        logic div_done;
        logic found;
    } sts_t;

endpackage

@@ rtl/pbc3d_datapath.sv @@
// ----------------------------------------------------------------------------
// pbc3d_datapath
// Bound registers, point state, face set-up and a shared restoring divider.
// ----------------------------------------------------------------------------
module pbc3d_datapath
    import pbc3d_pkg::*;
#(
    parameter int COORD_WIDTH = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [IDX_W-1:0]       cfg_idx,
    input  logic [COORD_WIDTH-1:0] cfg_data,
    input  logic [COORD_WIDTH-1:0] in_x,
    input  logic [COORD_WIDTH-1:0] in_y,
    input  logic [COORD_WIDTH-1:0] in_z,
    input  logic                   in_start,
    input  cmd_t                   cmd,
    output sts_t                   sts,
    output logic [COORD_WIDTH-1:0] res_x,
    output logic [COORD_WIDTH-1:0] res_y,
    output logic [COORD_WIDTH-1:0] res_z,
    output logic                   res_end
);

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 2;           // differences and magnitudes
    localparam int PW = 2 * DW;          // product
    localparam int QW = W + 2;           // quotient, saturated at 2^(W+1)
    localparam int CW = $clog2(PW + 1);
    localparam logic [QW-1:0] QLIM = QW'(1) << (W + 1);
    localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] RST_LO = -W'(3840);
    localparam logic signed [W-1:0] RST_HI = W'(3840);

    logic signed [W-1:0] lo_reg [3];
    logic signed [W-1:0] hi_reg [3];
    logic signed [W-1:0] cur_reg [3];
    logic signed [W-1:0] last_reg [3];
    logic signed [W-1:0] cand_reg [3];
    logic signed [W-1:0] best_reg [3];
    logic                last_in_reg;
    logic                inside_reg;
    logic                ok_reg;
    logic                found_reg;

    // face set-up
    logic [1:0]          ax_reg;
    logic signed [DW-1:0] a_reg;   // bound - prev_axis
    logic [1:0]          ob_reg;   // axis being divided

    // divider
    logic [PW-1:0]       num_reg;
    logic [DW-1:0]       den_reg;
    logic [DW:0]         rem_reg;
    logic [PW-1:0]       q_reg;
    logic [CW-1:0]       cnt_reg;
    logic                busy_reg;
    logic                neg_reg;
    logic                zero_reg;
    logic                done_reg;
    logic                mul_reg;
    logic [DW-1:0]       ma_reg;
    logic [DW-1:0]       mb_reg;

    function automatic logic [DW-1:0] magf(input logic signed [DW-1:0] v);
        magf = v[DW-1] ? DW'(-v) : v;
    endfunction

    function automatic logic signed [DW-1:0] sx(input logic signed [W-1:0] v);
        sx = DW'(v);
    endfunction

    function automatic logic in_ax(input logic signed [W-1:0] v,
                                   input logic signed [W-1:0] l,
                                   input logic signed [W-1:0] h);
        in_ax = (v > l) && (v < h);
    endfunction

    logic [1:0] fa;
    logic       fhigh;
    logic signed [W-1:0] fb;
    logic signed [DW-1:0] d_ax;
    logic       try_c;
    logic [1:0] oth;
    logic signed [DW-1:0] db;
    logic [DW:0] rem_sh;
    logic [QW-1:0] qsat;
    logic [QW-1:0] qr;
    logic signed [DW+1:0] rsum;
    logic signed [W-1:0] rclamp;

    always_comb
    begin
        fa    = cmd.face[2:1];
        fhigh = ~cmd.face[0];
        fb    = fhigh ? hi_reg[fa] : lo_reg[fa];
        d_ax  = sx(cur_reg[fa]) - sx(last_reg[fa]);
        try_c = (fhigh ? (cur_reg[fa] > fb) : (cur_reg[fa] < fb)) && (d_ax != '0);
        case (ax_reg)
            2'd0:    oth = cmd.axis_sel ? 2'd2 : 2'd1;
            2'd1:    oth = cmd.axis_sel ? 2'd2 : 2'd0;
            default: oth = cmd.axis_sel ? 2'd1 : 2'd0;
        endcase
        db = sx(cur_reg[oth]) - sx(last_reg[oth]);
        rem_sh = {rem_reg[DW-1:0], num_reg[PW-1]};
        // saturated quotient, rounded to nearest
        if (q_reg[PW-1:W+1] != '0)
            qsat = QLIM;
        else
            qsat = q_reg[QW-1:0];
        qr = qsat;
        if ((q_reg[PW-1:W+1] == '0) && ({rem_reg, 1'b0} >= {2'b00, den_reg}) && (qsat < QLIM))
            qr = qsat + QW'(1);
        rsum = neg_reg ? ((DW+2)'(last_reg[ob_reg]) - $signed((DW+2)'(qr)))
                       : ((DW+2)'(last_reg[ob_reg]) + $signed((DW+2)'(qr)));
        if (zero_reg)
            rclamp = last_reg[ob_reg];
        else if (rsum > (DW+2)'(CMAX))
            rclamp = CMAX;
        else if (rsum < (DW+2)'(CMIN))
            rclamp = CMIN;
        else
            rclamp = rsum[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                lo_reg[k]   <= RST_LO;
                hi_reg[k]   <= RST_HI;
                last_reg[k] <= '0;
            end
            last_in_reg <= 1'b0;
            found_reg   <= 1'b0;
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            mul_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we && (cfg_idx < IDX_W'(NUM_REGS)))
            begin
                if (cfg_idx[0])
                    hi_reg[cfg_idx[2:1]] <= cfg_data;
                else
                    lo_reg[cfg_idx[2:1]] <= cfg_data;
            end
            if (cmd.load)
            begin
                cur_reg[0] <= in_x;
                cur_reg[1] <= in_y;
                cur_reg[2] <= in_z;
                if (in_start)
                    last_in_reg <= 1'b0;
                found_reg <= 1'b0;
                inside_reg <= in_ax(in_x, lo_reg[0], hi_reg[0])
                           && in_ax(in_y, lo_reg[1], hi_reg[1])
                           && in_ax(in_z, lo_reg[2], hi_reg[2]);
            end
            if (cmd.emit_inside)
            begin
                for (int k = 0; k < 3; k++)
                    last_reg[k] <= cur_reg[k];
                last_in_reg <= 1'b1;
            end
            if (cmd.emit_cross)
                last_in_reg <= 1'b0;
            if (cmd.face_start)
            begin
                ax_reg    <= fa;
                a_reg     <= sx(fb) - sx(last_reg[fa]);
                den_reg   <= magf(d_ax);
                for (int k = 0; k < 3; k++)
                    cand_reg[k] <= (2'(k) == fa) ? fb : cur_reg[k];
                ok_reg    <= 1'b1;
            end
            if (cmd.axis_start)
            begin
                ob_reg   <= oth;
                neg_reg  <= ((a_reg[DW-1]) != (db[DW-1]))
                            != ((sx(cur_reg[ax_reg]) - sx(last_reg[ax_reg])) < 0);
                zero_reg <= (a_reg == '0) || (db == '0);
                ma_reg   <= magf(a_reg);
                mb_reg   <= magf(db);
                mul_reg  <= 1'b1;
            end
            if (mul_reg)
            begin
                // one registered multiply, then bit-serial division
                mul_reg  <= 1'b0;
                num_reg  <= PW'(ma_reg) * PW'(mb_reg);
                rem_reg  <= '0;
                q_reg    <= '0;
                cnt_reg  <= CW'(PW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                num_reg <= {num_reg[PW-2:0], 1'b0};
                if (rem_sh >= {1'b0, den_reg})
                begin
                    rem_reg <= rem_sh - {1'b0, den_reg};
                    q_reg   <= {q_reg[PW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    q_reg   <= {q_reg[PW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            if (done_reg)
            begin
                cand_reg[ob_reg] <= rclamp;
                if (!in_ax(rclamp, lo_reg[ob_reg], hi_reg[ob_reg]))
                    ok_reg <= 1'b0;
            end
            if (cmd.face_commit && ok_reg)
            begin
                for (int k = 0; k < 3; k++)
                    best_reg[k] <= cand_reg[k];
                found_reg <= 1'b1;
            end
        end
    end

    assign sts.in_box      = inside_reg;
    assign sts.last_inside = last_in_reg;
    assign sts.face_try    = try_c;
    assign sts.div_done    = done_reg;
    assign sts.found       = found_reg;

    assign res_x   = cmd.emit_cross ? best_reg[0] : cur_reg[0];
    assign res_y   = cmd.emit_cross ? best_reg[1] : cur_reg[1];
    assign res_z   = cmd.emit_cross ? best_reg[2] : cur_reg[2];
    assign res_end = cmd.emit_cross;

endmodule

@@ rtl/pbc3d_ctrl.sv @@
// ----------------------------------------------------------------------------
// pbc3d_ctrl
// Sequencer: inside test, six face trials with two divides for each face that is tried, output hold.
// ----------------------------------------------------------------------------
module pbc3d_ctrl
    import pbc3d_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    input  sts_t sts,
    output cmd_t cmd,
    output logic emit_load,
    output logic emit_end
);
`include "polyline_box_clipper_3d_core_assert.svh"

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_JUDGE  = 7'b0000010,
        S_FACE   = 7'b0000100,
        S_DIV    = 7'b0001000,
        S_WAIT   = 7'b0010000,
        S_COMMIT = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] face_reg, face_next;
    logic       sel_reg, sel_next;
    logic       ov_reg;

    always_comb
    begin
        state_next = state_reg;
        face_next  = face_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.face   = face_reg;
        cmd.axis_sel = sel_reg;
        emit_load  = 1'b0;
        emit_end   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !ov_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_JUDGE;
                end
            end
            S_JUDGE:
            begin
                if (sts.in_box)
                begin
                    cmd.emit_inside = 1'b1;
                    emit_load  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (!sts.last_inside)
                    state_next = S_IDLE;
                else
                begin
                    face_next  = 3'd0;
                    state_next = S_FACE;
                end
            end
            S_FACE:
            begin
                if (sts.face_try)
                begin
                    cmd.face_start = 1'b1;
                    sel_next   = 1'b0;
                    state_next = S_DIV;
                end
                else if (face_reg == 3'd5)
                    state_next = S_DONE;
                else
                    face_next = face_reg + 3'd1;
            end
            S_DIV:
            begin
                cmd.axis_start = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (sts.div_done)
                begin
                    if (sel_reg)
                        state_next = S_COMMIT;
                    else
                    begin
                        sel_next   = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_COMMIT:
            begin
                cmd.face_commit = 1'b1;
                if (face_reg == 3'd5)
                    state_next = S_DONE;
                else
                begin
                    face_next  = face_reg + 3'd1;
                    state_next = S_FACE;
                end
            end
            S_DONE:
            begin
                cmd.emit_cross = 1'b1;
                emit_load  = sts.found;
                emit_end   = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            face_reg  <= '0;
            sel_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            face_reg  <= face_next;
            sel_reg   <= sel_next;
            if (emit_load)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    // new request only taken when idle and once the previous result has left
    assign in_stall  = (state_reg != S_IDLE) || ov_reg;
    assign out_valid = ov_reg;

    `PBC_ASSERT_IMP(a_load_idle, clk, rst_n, cmd.load, !ov_reg)
    `PBC_ASSERT_IMP(a_emit_free, clk, rst_n, emit_load, !ov_reg)
    `PBC_ASSERT_NXT(a_load_judge, clk, rst_n, cmd.load, state_reg == S_JUDGE)
    `PBC_ASSERT_IMP(a_face_range, clk, rst_n, state_reg == S_FACE, face_reg <= 3'd5)

endmodule

@@ rtl/polyline_box_clipper_3d_core.sv @@
// ----------------------------------------------------------------------------
// polyline_box_clipper_3d_core
// Clips a 3D point stream against an open axis-aligned box.
// ----------------------------------------------------------------------------
// One request at a time. A point inside the box and one that is dropped
// finish after the inside test; an exit point then runs the face trials,
// and each face that is tried does two divides on the shared
// multiply-then-bit-serial divider. A result waits in the output register;
// the next request is taken once it has been collected.
module polyline_box_clipper_3d_core
    import pbc3d_pkg::*;
#(
    parameter int COORD_WIDTH = 24,
    parameter int FRAC_BITS   = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [IDX_W-1:0]       cfg_index,
    input  logic [COORD_WIDTH-1:0] cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [COORD_WIDTH-1:0] pos_x,
    input  logic [COORD_WIDTH-1:0] pos_y,
    input  logic [COORD_WIDTH-1:0] pos_z,
    input  logic                   track_start,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [COORD_WIDTH-1:0] out_x,
    output logic [COORD_WIDTH-1:0] out_y,
    output logic [COORD_WIDTH-1:0] out_z,
    output logic                   segment_end
);

    // scale only: the ratio arithmetic is independent of the fraction width
    localparam int FB = FRAC_BITS;

    cmd_t cmd;
    sts_t sts;
    logic emit_load, emit_end;
    logic [COORD_WIDTH-1:0] rx, ry, rz;
    logic re;
    logic [COORD_WIDTH-1:0] ox_reg, oy_reg, oz_reg;
    logic oe_reg;

    pbc3d_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall),
        .sts(sts), .cmd(cmd),
        .emit_load(emit_load), .emit_end(emit_end)
    );

    pbc3d_datapath #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
        .in_x(pos_x), .in_y(pos_y), .in_z(pos_z), .in_start(track_start),
        .cmd(cmd), .sts(sts),
        .res_x(rx), .res_y(ry), .res_z(rz), .res_end(re)
    );

    always_ff @(posedge clk)
    begin
        if (emit_load && (FB >= 0))
        begin
            ox_reg <= rx;
            oy_reg <= ry;
            oz_reg <= rz;
            oe_reg <= re & emit_end;
        end
    end

    assign out_x       = ox_reg;
    assign out_y       = oy_reg;
    assign out_z       = oz_reg;
    assign segment_end = oe_reg;

endmodule
